// ----- sv/jids_pkg.sv -----
package jids_pkg;

   localparam int DATA_W      = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int KIND_W      = 2;

   // command kinds carried on req_tuser
   localparam logic [KIND_W-1:0] KIND_IR   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

   // tdi level outside the shifted bits
   localparam logic TDI_IDLE = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_IR   = 3'b010,
      MODE_DR   = 3'b100
   } mode_type;

   typedef struct packed {
      logic              accepted;
      logic              tck_pulse;
      logic              tms;
      logic              tdi;
      logic              done_res;
      logic [DATA_W-1:0] captured;
   } result_type;

endpackage

// ----- sv/jtag_ir_dr_shift_master.sv -----
// JTAG shift master from Run-Test/Idle: a start item (req_tuser 0 for an
// IR_BITS instruction, 1 for a DR_BITS data word) loads the word, and each
// following tick item (req_tuser 2) yields one TCK pulse with its TMS and TDI
// levels while the TDO level sent with that tick is captured. An instruction
// shift takes IR_BITS+6 ticks, a data shift DR_BITS+5; the item carrying the
// final pulse has rsp_tlast set and the captured word. Every item, refused or
// idle ones included, gives exactly one result item. The block takes one item
// per clock while results are taken: one input register, then the TAP
// sequencer and the result register; an item is held in the input register
// and its result in the result register. A stalled result holds the sequencer
// and leaves room for one more item in the input register.
module jtag_ir_dr_shift_master #(
   parameter int IR_BITS = 8,
   parameter int DR_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [jids_pkg::REQ_TDATA_W-1:0]    req_tdata,  // data[15:0], tdo[16], zero pad
   input  logic [jids_pkg::KIND_W-1:0]         req_tuser,  // kind[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [jids_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // accepted[0], tck_pulse[1],
                                                          // tms[2], tdi[3], captured[19:4],
                                                          // zero pad
   output logic                                rsp_tlast   // done_res
);
   import jids_pkg::*;

   logic                in_valid_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [DATA_W-1:0]   data_ff;
   logic                tdo_ff;

   logic                out_valid_ff;
   result_type          res_ff;
   result_type          res_in;

   logic                step_en;

   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         kind_ff <= req_tuser;
         data_ff <= req_tdata[DATA_W-1:0];
         tdo_ff  <= req_tdata[DATA_W];
      end
   end

   jids_seq #(
      .IR_BITS(IR_BITS),
      .DR_BITS(DR_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .kind    (kind_ff),
      .data    (data_ff),
      .tdo     (tdo_ff),
      .result  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = res_ff.done_res;
   assign rsp_tdata  = {(RSP_TDATA_W - DATA_W - 4)'(0), res_ff.captured, res_ff.tdi,
                        res_ff.tms, res_ff.tck_pulse, res_ff.accepted};

endmodule

// ----- sv/jids_seq.sv -----
module jids_seq #(
   parameter int IR_BITS = 8,
   parameter int DR_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [jids_pkg::KIND_W-1:0]   kind,
   input  logic [jids_pkg::DATA_W-1:0]   data,
   input  logic                          tdo,
   output jids_pkg::result_type          result
);
   import jids_pkg::*;

   localparam int MAX_TOTAL = (IR_BITS + 6 > DR_BITS + 5) ? IR_BITS + 6 : DR_BITS + 5;
   localparam int CNT_W0    = $clog2(MAX_TOTAL + 1);
   localparam int CNT_W     = (CNT_W0 > 5) ? CNT_W0 : 5;

   localparam logic [CNT_W-1:0] PRE_IR = CNT_W'(4);
   localparam logic [CNT_W-1:0] PRE_DR = CNT_W'(3);
   localparam logic [CNT_W-1:0] IR_N   = CNT_W'(IR_BITS);
   localparam logic [CNT_W-1:0] DR_N   = CNT_W'(DR_BITS);
   localparam logic [CNT_W-1:0] ONE    = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO    = CNT_W'(2);
   localparam logic [CNT_W-1:0] WORD_N = CNT_W'(DATA_W);

   mode_type            mode_ff, mode_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DATA_W-1:0]   shift_ff, shift_in;
   logic [DATA_W-1:0]   cap_ff, cap_in;

   logic                is_ir;
   logic [CNT_W-1:0]    pre;
   logic [CNT_W-1:0]    nbits;
   logic [CNT_W-1:0]    k;
   logic [CNT_W-1:0]    pos;
   logic [CNT_W-1:0]    src;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      cap_in   = cap_ff;
      result   = '0;
      result.tdi = TDI_IDLE;

      is_ir = (mode_ff == MODE_IR);
      pre   = is_ir ? PRE_IR : PRE_DR;
      nbits = is_ir ? IR_N : DR_N;
      k     = count_ff - pre;
      pos   = nbits - ONE - k;
      // instruction goes out lsb first, data msb first; capture always lands at pos
      src   = is_ir ? k : pos;

      if (step_en) begin
         unique case (kind) inside
            KIND_IR, KIND_DR: begin
               if (mode_ff == MODE_IDLE) begin
                  mode_in  = (kind == KIND_IR) ? MODE_IR : MODE_DR;
                  count_in = '0;
                  shift_in = data;
                  cap_in   = '0;
                  result.accepted = 1'b1;
               end
            end
            KIND_TICK: begin
               if (mode_ff != MODE_IDLE) begin
                  result.tck_pulse = 1'b1;
                  if (count_ff < pre) begin
                     result.tms = is_ir ? (count_ff < TWO) : (count_ff == '0);
                  end else if (count_ff < pre + nbits) begin
                     result.tms = (k == nbits - ONE);
                     // bits beyond the loaded word go out as zero
                     if (src < WORD_N) begin
                        result.tdi = shift_ff[src[3:0]];
                     end else begin
                        result.tdi = 1'b0;
                     end
                     if (tdo && (pos < WORD_N)) begin
                        cap_in[pos[3:0]] = 1'b1;
                     end
                  end else begin
                     result.tms = (count_ff == pre + nbits);
                  end
                  count_in = count_ff + ONE;
                  if (count_in >= pre + nbits + TWO) begin
                     result.done_res = 1'b1;
                     result.captured = cap_in;
                     mode_in  = MODE_IDLE;
                     count_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
         cap_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         cap_ff   <= cap_in;
      end
   end

endmodule

// ----- sv/jids_checker.sv -----
module jids_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // the end of a shift is always a pulse, and a start never pulses
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[1] && !rsp_tdata[0])
      else $error("done without a tck pulse");

   a_start_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[1] && !rsp_tlast)
      else $error("accepted start also pulsed");

   // captured word only shows with done
   a_cap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[19:4] == 16'd0)
      else $error("captured word outside done");

   // no pulse: tms low, tdi at idle level
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> !rsp_tdata[2] && rsp_tdata[3])
      else $error("tms or tdi active without a pulse");

endmodule

bind jtag_ir_dr_shift_master jids_checker u_jids_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
